// ===== sv/srtx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtx_pkg
// Shared types, constants and the symbol table lookup for the signed integer
// to radix text converter.
// ----------------------------------------------------------------------------
package srtx_pkg;

   localparam int NUM_W          = 32;
   localparam int SYM_W          = 8;
   localparam int RADIX_W        = 5;
   localparam int TABLE_W        = 64;
   localparam int TABLE_SLOTS    = 8;
   localparam int DIGIT_IDX_W    = 4;
   localparam int BITS_PER_CYC   = 8;
   localparam int DIV_CYC        = NUM_W / BITS_PER_CYC;
   localparam int DIV_CNT_W      = $clog2(DIV_CYC);

   localparam int MAX_RADIX_DEF  = 16;
   localparam int MAX_DIGITS_DEF = 32;

   localparam logic [RADIX_W-1:0] RADIX_RST   = 5'd10;
   localparam logic [TABLE_W-1:0] SYM_LO_RST  = 64'h3736353433323130;
   localparam logic [TABLE_W-1:0] SYM_HI_RST  = 64'h4645444342413938;

   localparam logic [SYM_W-1:0] SYM_FIRST = 8'h21;
   localparam logic [SYM_W-1:0] SYM_LAST  = 8'h7E;
   localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
   localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

   typedef enum logic [1:0] {
      CSR_RADIX   = 2'd0,
      CSR_SYM_LO  = 2'd1,
      CSR_SYM_HI  = 2'd2
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_DIV   = 5'b00100,
      ST_LOAD  = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   function automatic logic [SYM_W-1:0] sym_of(
      input logic [TABLE_W-1:0]     lo,
      input logic [TABLE_W-1:0]     hi,
      input logic [DIGIT_IDX_W-1:0] v
   );
      logic [TABLE_W-1:0] word;
      word = v[DIGIT_IDX_W-1] ? hi : lo;
      return word[v[DIGIT_IDX_W-2:0]*SYM_W +: SYM_W];
   endfunction

endpackage

// ===== sv/srtx_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtx_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module srtx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/signed_int_to_radix_text.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_radix_text
// Converts a signed 32-bit number to text in a configured radix, one symbol
// byte per response beat, most significant digit first.
// ----------------------------------------------------------------------------
// A number is taken when start is high and busy is low; busy then stays high
// until the text is out or the number is dropped. Each response beat is on
// rsp_* for one cycle with rsp_valid high and cannot be held off. A taken
// number goes through symbol table checking (one table entry per cycle),
// then the shared divider (8 quotient bits per cycle), then priming of the
// digit buffer, then emission of the digits; the '-' of a negative number is
// issued from the priming state, ahead of the digits. If radix is below 2 or
// above MAX_RADIX, or a used symbol is out of '!'..'~', is '+' or '-', or
// repeats, the number produces no beats.
// ----------------------------------------------------------------------------
module signed_int_to_radix_text
   import srtx_pkg::*;
#(
   parameter int MAX_RADIX  = MAX_RADIX_DEF,
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic signed [NUM_W-1:0] req_number,
   output logic                 rsp_valid,
   output logic [SYM_W-1:0]     rsp_symbol,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [TABLE_W-1:0]   csr_data
);

   localparam int REM_W = $clog2(MAX_RADIX);
   localparam int AW    = $clog2(MAX_DIGITS);
   localparam int CNT_W = $clog2(MAX_DIGITS + 1);

   state_type                state_ff, state_in;
   logic [RADIX_W-1:0]       radix_ff, radix_in;
   logic [TABLE_W-1:0]       sym_lo_ff, sym_lo_in;
   logic [TABLE_W-1:0]       sym_hi_ff, sym_hi_in;
   logic                     neg_ff, neg_in;
   logic [NUM_W-1:0]         mag_ff, mag_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]     chunk_ff, chunk_in;
   logic [DIGIT_IDX_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]         nd_ff, nd_in;
   logic [AW-1:0]            ptr_ff, ptr_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]         rsp_symbol_ff, rsp_symbol_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     radix_bad;
   logic [SYM_W-1:0]         chk_sym;
   logic                     chk_bad;
   logic [NUM_W-1:0]         div_mag;
   logic [REM_W-1:0]         div_rem;
   logic                     ram_we;
   logic [AW-1:0]            ram_rd_addr;
   logic [REM_W-1:0]         ram_rd_data;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign radix_bad = (radix_ff < RADIX_W'(2)) || (radix_ff > RADIX_W'(MAX_RADIX));

   // table entry check: range, reserved signs, repeat against higher entries
   always_comb begin
      logic dup;
      dup = 1'b0;
      chk_sym = sym_of(sym_lo_ff, sym_hi_ff, idx_ff);
      for (int b = 0; b < 2 * TABLE_SLOTS; b++) begin
         if ((DIGIT_IDX_W'(b) > idx_ff) && (RADIX_W'(b) < radix_ff) &&
             (sym_of(sym_lo_ff, sym_hi_ff, DIGIT_IDX_W'(b)) == chk_sym)) begin
            dup = 1'b1;
         end
      end
      chk_bad = dup || (chk_sym < SYM_FIRST) || (chk_sym > SYM_LAST) ||
                (chk_sym == SYM_PLUS) || (chk_sym == SYM_MINUS);
   end

   // shared divider: 8 restoring long-division steps per cycle
   always_comb begin
      logic [NUM_W-1:0] m;
      logic [REM_W-1:0] r;
      logic [REM_W:0]   rs;
      m = mag_ff;
      r = rem_ff;
      rs = '0;
      for (int i = 0; i < BITS_PER_CYC; i++) begin
         rs = {r, m[NUM_W-1]};
         m  = {m[NUM_W-2:0], 1'b0};
         if (RADIX_W'(rs) >= radix_ff) begin
            r    = REM_W'(RADIX_W'(rs) - radix_ff);
            m[0] = 1'b1;
         end else begin
            r = rs[REM_W-1:0];
         end
      end
      div_mag = m;
      div_rem = r;
   end

   assign ram_we      = (state_ff == ST_DIV) && (chunk_ff == DIV_CNT_W'(DIV_CYC - 1));
   assign ram_rd_addr = (state_ff == ST_EMIT) ? (ptr_ff - AW'(1)) : ptr_ff;

   srtx_ram #(
      .WIDTH (REM_W),
      .DEPTH (MAX_DIGITS)
   ) u_digits (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (nd_ff[AW-1:0]),
      .wr_data (div_rem),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      radix_in      = radix_ff;
      sym_lo_in     = sym_lo_ff;
      sym_hi_in     = sym_hi_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      rem_in        = rem_ff;
      chunk_in      = chunk_ff;
      idx_in        = idx_ff;
      nd_in         = nd_ff;
      ptr_in        = ptr_ff;
      rsp_valid_in  = 1'b0;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in   = 1'b0;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RADIX:  radix_in  = csr_data[RADIX_W-1:0];
            CSR_SYM_LO: sym_lo_in = csr_data;
            CSR_SYM_HI: sym_hi_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               neg_in   = req_number[NUM_W-1];
               mag_in   = req_number[NUM_W-1] ? (NUM_W'(0) - NUM_W'(req_number))
                                              : NUM_W'(req_number);
               rem_in   = '0;
               chunk_in = '0;
               idx_in   = '0;
               nd_in    = '0;
               if (!radix_bad) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (chk_bad) begin
               state_in = ST_IDLE;
            end else if (RADIX_W'(idx_ff) == radix_ff - RADIX_W'(1)) begin
               state_in = ST_DIV;
            end else begin
               idx_in = idx_ff + DIGIT_IDX_W'(1);
            end
         end
         ST_DIV: begin
            chunk_in = chunk_ff + DIV_CNT_W'(1);
            mag_in   = div_mag;
            rem_in   = div_rem;
            if (ram_we) begin
               rem_in = '0;
               nd_in  = nd_ff + CNT_W'(1);
               ptr_in = nd_ff[AW-1:0];
               if ((div_mag == '0) || (nd_ff == CNT_W'(MAX_DIGITS - 1))) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            rsp_valid_in  = neg_ff;
            rsp_symbol_in = SYM_MINUS;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid_in  = 1'b1;
            rsp_symbol_in = sym_of(sym_lo_ff, sym_hi_ff, DIGIT_IDX_W'(ram_rd_data));
            rsp_last_in   = (ptr_ff == '0);
            ptr_in        = ptr_ff - AW'(1);
            if (ptr_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= RADIX_RST;
         sym_lo_ff    <= SYM_LO_RST;
         sym_hi_ff    <= SYM_HI_RST;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radix_ff     <= radix_in;
         sym_lo_ff    <= sym_lo_in;
         sym_hi_ff    <= sym_hi_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
      neg_ff        <= neg_in;
      mag_ff        <= mag_in;
      rem_ff        <= rem_in;
      chunk_ff      <= chunk_in;
      idx_ff        <= idx_in;
      nd_ff         <= nd_in;
      ptr_ff        <= ptr_in;
      rsp_symbol_ff <= rsp_symbol_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last   = rsp_last_ff;

`ifndef ASSERT_OFF
   a_beat_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response beat without a number in flight");

   a_beats_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> rsp_valid)
      else $error("gap inside a number's text");

   a_quiet_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !rsp_valid)
      else $error("beat right after last");

   a_digit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (nd_ff < CNT_W'(MAX_DIGITS)))
      else $error("digit buffer overrun");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the signed integer to radix text converter.
// ----------------------------------------------------------------------------
// Numbers are queued by the stimulus process and presented by a driver on the
// falling edge. A monitor on the rising edge takes each accepted number and
// expands it into the symbol beats it should produce under the current radix
// and symbol table. It then checks every response beat against the oldest
// one still due. Directed cases come first: zero, the extremes, bad radixes,
// bad, signed and repeated symbols, unused table slots and a write to an
// unmapped register. Random phases follow, each with a fresh table.
// ----------------------------------------------------------------------------
module tb;
   import srtx_pkg::*;

   localparam logic [1:0] CSR_NONE = 2'd3;
   localparam int SETTLE     = 200;
   localparam int LIMIT      = 600000;
   localparam int RAND_ITEMS = 250;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             is_last;
   } text_beat_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    start      = 1'b0;
   logic                    busy;
   logic signed [NUM_W-1:0] req_number = '0;
   logic                    rsp_valid;
   logic [SYM_W-1:0]        rsp_symbol;
   logic                    rsp_last;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [1:0]              csr_index  = '0;
   logic [TABLE_W-1:0]      csr_data   = '0;

   logic [NUM_W-1:0]   number_q [$];
   text_beat_type      text_q [$];
   logic               number_taken = 1'b0;
   int                 gap_pct      = 0;
   int                 bad_count    = 0;
   int                 cycle_count  = 0;
   logic [RADIX_W-1:0] cfg_radix    = RADIX_RST;
   logic [TABLE_W-1:0] cfg_lo       = SYM_LO_RST;
   logic [TABLE_W-1:0] cfg_hi       = SYM_HI_RST;

   signed_int_to_radix_text uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_number (req_number),
      .rsp_valid  (rsp_valid),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [SYM_W-1:0] glyph(input logic [3:0] digit);
      logic [2*TABLE_W-1:0] both;
      both = {cfg_hi, cfg_lo};
      return both[digit*SYM_W +: SYM_W];
   endfunction

   function automatic logic table_usable();
      logic [SYM_W-1:0] s;
      if (cfg_radix < 2 || cfg_radix > MAX_RADIX_DEF) return 1'b0;
      for (int a = 0; a < cfg_radix; a++) begin
         s = glyph(a[3:0]);
         if (s < SYM_FIRST || s > SYM_LAST || s == SYM_PLUS || s == SYM_MINUS) return 1'b0;
         for (int b = a + 1; b < cfg_radix; b++)
            if (glyph(b[3:0]) == s) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void predict_text(input logic [NUM_W-1:0] raw);
      logic [NUM_W-1:0] mag;
      logic [NUM_W-1:0] base;
      logic [3:0]       digs [MAX_DIGITS_DEF];
      text_beat_type    beat;
      int               n;
      if (!table_usable()) return;
      base = NUM_W'(cfg_radix);
      mag  = raw[NUM_W-1] ? -raw : raw;
      n    = 0;
      do begin
         digs[n] = 4'(mag % base);
         n++;
         mag = mag / base;
      end while (mag != 0 && n < MAX_DIGITS_DEF);
      if (raw[NUM_W-1]) begin
         beat.symbol  = SYM_MINUS;
         beat.is_last = 1'b0;
         text_q.push_back(beat);
      end
      for (int k = n - 1; k >= 0; k--) begin
         beat.symbol  = glyph(digs[k]);
         beat.is_last = (k == 0);
         text_q.push_back(beat);
      end
   endfunction

   // distinct legal symbols in the used slots, anything at all above them
   function automatic logic [2*TABLE_W-1:0] random_table(input int r);
      logic [SYM_W-1:0]     pick [16];
      logic [2*TABLE_W-1:0] both;
      logic                 clash;
      for (int i = 0; i < 16; i++) begin
         do begin
            pick[i] = SYM_W'($urandom_range(SYM_FIRST, SYM_LAST));
            clash = (pick[i] == SYM_PLUS || pick[i] == SYM_MINUS);
            for (int j = 0; j < i; j++)
               if (pick[j] == pick[i]) clash = 1'b1;
         end while (clash);
         if (i >= r && $urandom_range(1)) pick[i] = SYM_W'($urandom);
         both[i*SYM_W +: SYM_W] = pick[i];
      end
      return both;
   endfunction

   function automatic logic [NUM_W-1:0] random_number();
      logic [NUM_W-1:0] v;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return $urandom;
         5, 6: begin
            v = NUM_W'($urandom_range(40));
            return $urandom_range(1) ? -v : v;
         end
         7: begin
            case ($urandom_range(3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return '1;
               default: return '0;
            endcase
         end
         default: begin
            v = $urandom >> $urandom_range(31);
            return $urandom_range(1) ? -v : v;
         end
      endcase
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || number_taken) begin
         if (number_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
            start      <= 1'b1;
            req_number <= number_q.pop_front();
         end else begin
            start      <= 1'b0;
            req_number <= $urandom;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      text_beat_type want;
      if (reset) begin
         number_taken <= 1'b0;
         cfg_radix    <= RADIX_RST;
         cfg_lo       <= SYM_LO_RST;
         cfg_hi       <= SYM_HI_RST;
      end else begin
         number_taken <= start && !busy;
         if (start && !busy) predict_text(req_number);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RADIX:  cfg_radix <= csr_data[RADIX_W-1:0];
               CSR_SYM_LO: cfg_lo    <= csr_data;
               CSR_SYM_HI: cfg_hi    <= csr_data;
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (text_q.size() == 0) begin
               bad_count++;
               $display("%0t: unexpected beat, expected none, got symbol %h last %b",
                        $time, rsp_symbol, rsp_last);
            end else begin
               want = text_q.pop_front();
               if (rsp_symbol !== want.symbol) begin
                  bad_count++;
                  $display("%0t: symbol mismatch, expected %h got %h",
                           $time, want.symbol, rsp_symbol);
               end
               if (rsp_last !== want.is_last) begin
                  bad_count++;
                  $display("%0t: last mismatch, expected %b got %b",
                           $time, want.is_last, rsp_last);
               end
            end
         end
      end
   end

   task automatic wait_idle();
      do @(posedge clock);
      while (!(number_q.size() == 0 && !start && text_q.size() == 0 && !busy));
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [TABLE_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      csr_index <= 2'($urandom);
      csr_data  <= {$urandom, $urandom};
   endtask

   task automatic set_table(input logic [RADIX_W-1:0] r, input logic [TABLE_W-1:0] lo,
                            input logic [TABLE_W-1:0] hi, input int gap);
      wait_idle();
      write_reg(CSR_RADIX, {$urandom, 27'($urandom), r});
      write_reg(CSR_SYM_LO, lo);
      write_reg(CSR_SYM_HI, hi);
      gap_pct = gap;
   endtask

   // stimulus
   initial begin
      logic [2*TABLE_W-1:0] both;
      int                   gaps [4];
      int                   r, k, flaw, n, taken, phase;
      gaps = '{0, 53, 0, 12};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      number_q = '{32'h0, 32'h1, '1, -32'sd10, 32'h7FFF_FFFF, 32'h8000_0000};
      set_table(16, SYM_LO_RST, SYM_HI_RST, 53);
      number_q = '{'1, 32'h7FFF_FFFF, 32'h0};
      set_table(2, SYM_LO_RST, SYM_HI_RST, 0);
      number_q = '{32'h8000_0000, 32'h7FFF_FFFF};
      set_table(0, SYM_LO_RST, SYM_HI_RST, 12);
      number_q.push_back(32'd5);
      set_table(1, SYM_LO_RST, SYM_HI_RST, 0);
      number_q.push_back(32'd5);
      set_table(17, SYM_LO_RST, SYM_HI_RST, 0);
      number_q.push_back(32'd7);
      set_table(31, SYM_LO_RST, SYM_HI_RST, 0);
      number_q.push_back(-32'sd7);
      set_table(10, "7654 210", SYM_HI_RST, 0);
      number_q.push_back(32'd1);
      set_table(10, 64'h3736_357F_3332_3130, SYM_HI_RST, 0);
      number_q.push_back(32'd1);
      set_table(10, "765+3210", SYM_HI_RST, 0);
      number_q.push_back(32'd1);
      set_table(10, "7654321-", SYM_HI_RST, 0);
      number_q.push_back(32'd1);
      set_table(10, "76543211", SYM_HI_RST, 0);
      number_q.push_back(32'd1);
      set_table(10, '0, SYM_HI_RST, 0);
      number_q.push_back(32'd1);
      // upper half of the table is junk but out of reach at radix 8
      set_table(8, "~654321!", '1, 53);
      write_reg(CSR_NONE, '0);
      number_q = '{-32'sd123, 32'd8};

      taken = 0;
      phase = 0;
      while (taken < RAND_ITEMS) begin
         case ($urandom_range(7))
            0, 1:    r = 16;
            2:       r = 2;
            default: r = $urandom_range(2, 16);
         endcase
         both = random_table(r);
         k    = $urandom_range(r - 1);
         flaw = ($urandom_range(7) == 0) ? $urandom_range(1, 6) : 0;
         case (flaw)
            1: r = $urandom_range(1);
            2: r = $urandom_range(17, 31);
            3: both[k*SYM_W +: SYM_W] = SYM_W'($urandom_range(0, 32));
            4: both[k*SYM_W +: SYM_W] = SYM_W'($urandom_range(127, 255));
            5: both[k*SYM_W +: SYM_W] = $urandom_range(1) ? SYM_PLUS : SYM_MINUS;
            6: both[k*SYM_W +: SYM_W] = both[((k + 1) % r)*SYM_W +: SYM_W];
            default: ;
         endcase
         set_table(RADIX_W'(r), both[TABLE_W-1:0], both[2*TABLE_W-1:TABLE_W],
                   gaps[phase % 4]);
         n = (flaw != 0) ? 3 : $urandom_range(10, 30);
         for (int i = 0; i < n; i++) number_q.push_back(random_number());
         if (flaw == 0) taken += n;
         phase++;
      end

      wait_idle();
      if (bad_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

endmodule
